// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port checker of the triangle unit.
// Depends on signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that a condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/core/tna_pkg.sv =====
// Package of the triangle normal and area unit: widths, constants and payload types.
// Used by every module of the block; depends on nothing.
package tna_pkg;

    localparam int COORD_W    = 16;
    localparam int EDGE_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int HALF_W     = MAG_W / 2;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int RAD_SHIFT  = 28;
    localparam int ROOT_W     = (SQ_W + RAD_SHIFT) / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int QUO_W      = 16;
    localparam int DREM_W     = ROOT_W + 1;
    localparam int NORM_SHIFT = 28;
    localparam int FRAC_SHIFT = 14;
    localparam int NORM_W     = 16;
    localparam int AREA_W     = 33;

    localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
    } tna_verts_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic [AREA_W-1:0]        tri_area;
        logic                     degenerate;
    } tna_result_t;

    typedef struct packed {
        logic signed [CROSS_W-1:0] cx;
        logic signed [CROSS_W-1:0] cy;
        logic signed [CROSS_W-1:0] cz;
        logic                      degenerate;
    } tna_cross_t;

endpackage

// ===== rtl/core/tna_front.sv =====
// Front end of the triangle unit: takes vertices, forms the edges and their cross product.
// Depends on tna_pkg; feeds tna_queue.
module tna_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vert_valid,
    output logic                vert_ready,
    input  tna_pkg::tna_verts_t verts,
    output logic                push_valid,
    input  logic                push_ready,
    output tna_pkg::tna_cross_t push_item
);

    logic en;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;

    logic signed [tna_pkg::EDGE_W-1:0] edge_a_next [3];
    logic signed [tna_pkg::EDGE_W-1:0] edge_b_next [3];
    logic signed [tna_pkg::EDGE_W-1:0] edge_a_reg [3];
    logic signed [tna_pkg::EDGE_W-1:0] edge_b_reg [3];

    logic signed [tna_pkg::PROD_W-1:0] prod_next [6];
    logic signed [tna_pkg::PROD_W-1:0] prod_reg [6];

    tna_pkg::tna_cross_t cross_next;
    tna_pkg::tna_cross_t cross_reg;

    assign en         = !s3_valid_reg || push_ready;
    assign vert_ready = en;
    assign push_valid = s3_valid_reg;
    assign push_item  = cross_reg;

    always_comb
    begin
        edge_a_next[0] = {verts.v1_x[tna_pkg::COORD_W-1], verts.v1_x}
                       - {verts.v0_x[tna_pkg::COORD_W-1], verts.v0_x};
        edge_a_next[1] = {verts.v1_y[tna_pkg::COORD_W-1], verts.v1_y}
                       - {verts.v0_y[tna_pkg::COORD_W-1], verts.v0_y};
        edge_a_next[2] = {verts.v1_z[tna_pkg::COORD_W-1], verts.v1_z}
                       - {verts.v0_z[tna_pkg::COORD_W-1], verts.v0_z};
        edge_b_next[0] = {verts.v2_x[tna_pkg::COORD_W-1], verts.v2_x}
                       - {verts.v0_x[tna_pkg::COORD_W-1], verts.v0_x};
        edge_b_next[1] = {verts.v2_y[tna_pkg::COORD_W-1], verts.v2_y}
                       - {verts.v0_y[tna_pkg::COORD_W-1], verts.v0_y};
        edge_b_next[2] = {verts.v2_z[tna_pkg::COORD_W-1], verts.v2_z}
                       - {verts.v0_z[tna_pkg::COORD_W-1], verts.v0_z};
    end

    always_comb
    begin
        prod_next[0] = edge_a_reg[1] * edge_b_reg[2];
        prod_next[1] = edge_a_reg[2] * edge_b_reg[1];
        prod_next[2] = edge_a_reg[2] * edge_b_reg[0];
        prod_next[3] = edge_a_reg[0] * edge_b_reg[2];
        prod_next[4] = edge_a_reg[0] * edge_b_reg[1];
        prod_next[5] = edge_a_reg[1] * edge_b_reg[0];
    end

    always_comb
    begin
        cross_next.cx = tna_pkg::CROSS_W'(prod_reg[0]) - tna_pkg::CROSS_W'(prod_reg[1]);
        cross_next.cy = tna_pkg::CROSS_W'(prod_reg[2]) - tna_pkg::CROSS_W'(prod_reg[3]);
        cross_next.cz = tna_pkg::CROSS_W'(prod_reg[4]) - tna_pkg::CROSS_W'(prod_reg[5]);
        cross_next.degenerate = (cross_next.cx == '0) && (cross_next.cy == '0)
                              && (cross_next.cz == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= vert_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            edge_a_reg <= edge_a_next;
            edge_b_reg <= edge_b_next;
            prod_reg   <= prod_next;
            cross_reg  <= cross_next;
        end
    end

endmodule

// ===== rtl/core/tna_queue.sv =====
// Short queue between the front end and the back end of the triangle unit.
// Depends on tna_pkg for the item type.
module tna_queue
#(
    parameter int DEPTH = tna_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  tna_pkg::tna_cross_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tna_pkg::tna_cross_t pop_item
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tna_pkg::tna_cross_t slot_reg [DEPTH];

    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/tna_back.sv =====
// Back end of the triangle unit: squared length, pipelined square root, three pipelined
// dividers for the normal, area rounding and the output register. Depends on tna_pkg.
module tna_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  tna_pkg::tna_cross_t  pop_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output tna_pkg::tna_result_t res
);

    localparam int MAG_W   = tna_pkg::MAG_W;
    localparam int HALF_W  = tna_pkg::HALF_W;
    localparam int SQ_W    = tna_pkg::SQ_W;
    localparam int ROOT_W  = tna_pkg::ROOT_W;
    localparam int REM_W   = tna_pkg::REM_W;
    localparam int QUO_W   = tna_pkg::QUO_W;
    localparam int DREM_W  = tna_pkg::DREM_W;
    localparam int AREA_W  = tna_pkg::AREA_W;
    localparam int NORM_W  = tna_pkg::NORM_W;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degenerate;
    } side_t;

    typedef struct packed {
        logic [2:0]        neg;
        logic              degenerate;
        logic [AREA_W-1:0] area;
    } dside_t;

    logic en;

    logic signed [tna_pkg::CROSS_W-1:0] cross_c [3];
    logic [tna_pkg::CROSS_W-1:0]        abs_c [3];
    side_t                              side_next;
    logic [2*HALF_W-1:0]                hh_next [3];
    logic [2*HALF_W-1:0]                hl_next [3];
    logic [2*HALF_W-1:0]                ll_next [3];

    logic                b0_valid_reg;
    side_t               b0_side_reg;
    logic [2*HALF_W-1:0] hh_reg [3];
    logic [2*HALF_W-1:0] hl_reg [3];
    logic [2*HALF_W-1:0] ll_reg [3];

    logic            b1_valid_reg;
    side_t           b1_side_reg;
    logic [SQ_W-1:0] sq_next [3];
    logic [SQ_W-1:0] sq_reg [3];

    logic              sq_valid_reg [ROOT_W+1];
    side_t             sq_side_reg [ROOT_W+1];
    logic [SQ_W-1:0]   sq_s_reg [ROOT_W+1];
    logic [REM_W-1:0]  sq_rem_reg [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W+1];

    logic [ROOT_W-1:0]     len;
    logic [AREA_W+1:0]     area_sum;
    logic [AREA_W:0]       area_full;
    dside_t                dside_next;
    logic [DREM_W-1:0]     drem_next [3];

    logic              dv_valid_reg [QUO_W+1];
    dside_t            dv_side_reg [QUO_W+1];
    logic [ROOT_W-1:0] dv_len_reg [QUO_W+1];
    logic [DREM_W-1:0] dv_rem_reg [QUO_W+1][3];
    logic [QUO_W-1:0]  dv_q_reg [QUO_W+1][3];

    logic [QUO_W-1:0]    q_clamp [3];
    logic [NORM_W-1:0]   norm_c [3];
    tna_pkg::tna_result_t res_next;
    tna_pkg::tna_result_t res_reg;
    logic                 res_valid_reg;

    assign en        = !res_valid_reg || res_ready;
    assign pop_ready = en;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Magnitudes split in halves so that each square is three narrow products.
    always_comb
    begin
        cross_c[0] = pop_item.cx;
        cross_c[1] = pop_item.cy;
        cross_c[2] = pop_item.cz;
        side_next.degenerate = pop_item.degenerate;
        for (int c = 0; c < 3; c++)
        begin
            abs_c[c] = cross_c[c][tna_pkg::CROSS_W-1] ? -cross_c[c] : cross_c[c];
            side_next.mag[c] = abs_c[c][MAG_W-1:0];
            side_next.neg[c] = cross_c[c][tna_pkg::CROSS_W-1];
            hh_next[c] = side_next.mag[c][MAG_W-1:HALF_W] * side_next.mag[c][MAG_W-1:HALF_W];
            hl_next[c] = side_next.mag[c][MAG_W-1:HALF_W] * side_next.mag[c][HALF_W-1:0];
            ll_next[c] = side_next.mag[c][HALF_W-1:0] * side_next.mag[c][HALF_W-1:0];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sq_next[c] = (SQ_W'(hh_reg[c]) << (2 * HALF_W))
                       + (SQ_W'(hl_reg[c]) << (HALF_W + 1))
                       + SQ_W'(ll_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg    <= 1'b0;
            b1_valid_reg    <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            b0_valid_reg    <= pop_valid;
            b1_valid_reg    <= b0_valid_reg;
            sq_valid_reg[0] <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_side_reg    <= side_next;
            hh_reg         <= hh_next;
            hl_reg         <= hl_next;
            ll_reg         <= ll_next;
            b1_side_reg    <= b0_side_reg;
            sq_reg         <= sq_next;
            sq_side_reg[0] <= b1_side_reg;
            sq_s_reg[0]    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // One result bit of the square root per stage, most significant first.
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        localparam int K = ROOT_W - 1 - i;

        logic [1:0]       pair;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;

        if (2 * K >= tna_pkg::RAD_SHIFT)
        begin : g_bits
            assign pair = sq_s_reg[i][2 * K - tna_pkg::RAD_SHIFT + 1 -: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {sq_rem_reg[i][REM_W-3:0], pair};
        assign trial  = REM_W'({sq_root_reg[i], 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[i+1] <= sq_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    sq_rem_reg[i+1]  <= rem_sh - trial;
                    sq_root_reg[i+1] <= {sq_root_reg[i][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[i+1]  <= rem_sh;
                    sq_root_reg[i+1] <= {sq_root_reg[i][ROOT_W-2:0], 1'b0};
                end
                sq_s_reg[i+1]    <= sq_s_reg[i];
                sq_side_reg[i+1] <= sq_side_reg[i];
            end
        end
    end

    // The dividend is the magnitude scaled by 2^28 plus half the length; its upper part
    // seeds the remainder and its low bits come from the length itself.
    always_comb
    begin
        len       = sq_root_reg[ROOT_W];
        area_sum  = (AREA_W + 2)'(len[ROOT_W-1:tna_pkg::FRAC_SHIFT]) + 1'b1;
        area_full = area_sum[AREA_W+1:1];
        dside_next.neg        = sq_side_reg[ROOT_W].neg;
        dside_next.degenerate = sq_side_reg[ROOT_W].degenerate;
        dside_next.area       = area_full[AREA_W] ? '1 : area_full[AREA_W-1:0];
        for (int c = 0; c < 3; c++)
        begin
            drem_next[c] = (DREM_W'(sq_side_reg[ROOT_W].mag[c])
                            << (tna_pkg::NORM_SHIFT - QUO_W))
                         + DREM_W'(len >> (QUO_W + 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= sq_valid_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= dside_next;
            dv_len_reg[0]  <= len;
            for (int c = 0; c < 3; c++)
            begin
                dv_rem_reg[0][c] <= drem_next[c];
                dv_q_reg[0][c]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[j+1] <= dv_side_reg[j];
                dv_len_reg[j+1]  <= dv_len_reg[j];
            end
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_comp
            logic [DREM_W-1:0] r_sh;
            logic [DREM_W-1:0] divisor;

            assign r_sh    = {dv_rem_reg[j][c][DREM_W-2:0], dv_len_reg[j][QUO_W - j]};
            assign divisor = DREM_W'(dv_len_reg[j]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (r_sh >= divisor)
                    begin
                        dv_rem_reg[j+1][c] <= r_sh - divisor;
                        dv_q_reg[j+1][c]   <= {dv_q_reg[j][c][QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[j+1][c] <= r_sh;
                        dv_q_reg[j+1][c]   <= {dv_q_reg[j][c][QUO_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            q_clamp[c] = (dv_q_reg[QUO_W][c] > tna_pkg::ONE_Q14) ? tna_pkg::ONE_Q14
                                                                  : dv_q_reg[QUO_W][c];
            norm_c[c]  = dv_side_reg[QUO_W].neg[c] ? NORM_W'(-q_clamp[c])
                                                   : NORM_W'(q_clamp[c]);
        end
        if (dv_side_reg[QUO_W].degenerate)
        begin
            res_next.normal_x   = '0;
            res_next.normal_y   = '0;
            res_next.normal_z   = '0;
            res_next.tri_area   = '0;
            res_next.degenerate = 1'b1;
        end
        else
        begin
            res_next.normal_x   = norm_c[0];
            res_next.normal_y   = norm_c[1];
            res_next.normal_z   = norm_c[2];
            res_next.tri_area   = dv_side_reg[QUO_W].area;
            res_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= dv_valid_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/core/triangle_normal_and_area.sv =====
// Triangle unit normal and area. One triangle is accepted per clock and one result
// transfer leaves per clock when the output side keeps up. The path runs through the
// three-stage front end, one queue slot, three squaring stages (partial products,
// squares, sum), the 48-stage square root (one root bit per stage), one divider setup
// stage and the 16-stage dividers (one quotient bit per stage) before the output
// register. The front end and the back end stall independently, with QUEUE_DEPTH
// transfers of slack between them.
// Depends on tna_pkg, tna_front, tna_queue and tna_back.
module triangle_normal_and_area
#(
    parameter int QUEUE_DEPTH = tna_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vert_valid,
    output logic                 vert_ready,
    input  tna_pkg::tna_verts_t  verts,
    output logic                 res_valid,
    input  logic                 res_ready,
    output tna_pkg::tna_result_t res
);

    logic                push_valid;
    logic                push_ready;
    tna_pkg::tna_cross_t push_item;
    logic                pop_valid;
    logic                pop_ready;
    tna_pkg::tna_cross_t pop_item;

    tna_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .verts      (verts),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    tna_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    tna_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ===== rtl/core/tna_checker.sv =====
// Port checker of the triangle unit and the bind that attaches it to the top level.
// Depends on tna_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tna_port_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 res_valid,
    input logic                 res_ready,
    input tna_pkg::tna_result_t res
);

    `ASSERT_CLK(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res), "result changed while stalled")

    `ASSERT_CLK(a_degen_zero, res_valid && res.degenerate |-> res.normal_x == 0 && res.normal_y == 0 && res.normal_z == 0, "degenerate result has a nonzero normal")

    `ASSERT_NEVER(a_degen_area, res_valid && res.degenerate && res.tri_area != 0, "degenerate result has a nonzero area")

    `ASSERT_CLK(a_normal_range, res_valid && !res.degenerate |-> res.tri_area != 0 && res.normal_x >= -16'sd16384 && res.normal_x <= 16'sd16384 && res.normal_y >= -16'sd16384 && res.normal_y <= 16'sd16384 && res.normal_z >= -16'sd16384 && res.normal_z <= 16'sd16384, "normal out of range or zero area")

endmodule

bind triangle_normal_and_area tna_port_checker u_tna_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

// ===== test/tna_checker.sv =====
// Checker of the triangle normal and area unit: predicts each result and compares transfers.
// Depends on tna_pkg; instantiated by the testbench beside the block.
module tna_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vert_valid,
    input  logic                 vert_ready,
    input  tna_pkg::tna_verts_t  verts,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  tna_pkg::tna_result_t res,
    output int                   failures,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    tna_pkg::tna_result_t expected_results[$];
    int                   err_count = 0;

    assign failures = err_count;
    assign pending  = expected_results.size();

    function automatic logic [15:0] unit_component(longint c, logic [127:0] len);
        logic [127:0] m;
        logic [127:0] q;
        m = (c < 0) ? 128'(-c) : 128'(c);
        q = ((m << 28) + (len >> 1)) / len;
        if (q > 128'd16384)
        begin
            q = 128'd16384;
        end
        return (c < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic tna_pkg::tna_result_t predict_normal_area(tna_pkg::tna_verts_t t);
        longint               ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [127:0]         mx, my, mz;
        logic [127:0]         sq, rem, root, trial, area;
        tna_pkg::tna_result_t r;
        ax = longint'(t.v1_x) - longint'(t.v0_x);
        ay = longint'(t.v1_y) - longint'(t.v0_y);
        az = longint'(t.v1_z) - longint'(t.v0_z);
        bx = longint'(t.v2_x) - longint'(t.v0_x);
        by = longint'(t.v2_y) - longint'(t.v0_y);
        bz = longint'(t.v2_z) - longint'(t.v0_z);
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        r = '0;
        if (cx == 0 && cy == 0 && cz == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        mx = (cx < 0) ? 128'(-cx) : 128'(cx);
        my = (cy < 0) ? 128'(-cy) : 128'(cy);
        mz = (cz < 0) ? 128'(-cz) : 128'(cz);
        sq = mx * mx + my * my + mz * mz;
        sq = sq << 28;
        rem  = '0;
        root = '0;
        for (int k = 63; k >= 0; k--)
        begin
            rem   = (rem << 2) | ((sq >> (2 * k)) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 128'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        area = ((root >> 14) + 128'd1) >> 1;
        if (area > 128'h1_FFFF_FFFF)
        begin
            area = 128'h1_FFFF_FFFF;
        end
        r.normal_x = unit_component(cx, root);
        r.normal_y = unit_component(cy, root);
        r.normal_z = unit_component(cz, root);
        r.tri_area = 33'(area);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        tna_pkg::tna_result_t want;
        if (rst_n)
        begin
            if (vert_valid && vert_ready)
            begin
                expected_results.push_back(predict_normal_area(verts));
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result transfer", 1, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.normal_x !== want.normal_x)
                        report_mismatch("normal_x", res.normal_x, want.normal_x);
                    if (res.normal_y !== want.normal_y)
                        report_mismatch("normal_y", res.normal_y, want.normal_y);
                    if (res.normal_z !== want.normal_z)
                        report_mismatch("normal_z", res.normal_z, want.normal_z);
                    if (res.tri_area !== want.tri_area)
                        report_mismatch("tri_area", res.tri_area, want.tri_area);
                    if (res.degenerate !== want.degenerate)
                        report_mismatch("degenerate", res.degenerate, want.degenerate);
                end
            end
        end
    end
endmodule

// ===== test/testbench.sv =====
// Testbench top of the triangle normal and area unit: clock, reset, stimulus and verdict.
// Depends on tna_pkg, triangle_normal_and_area and tna_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 vert_valid = 1'b0;
    logic                 vert_ready;
    tna_pkg::tna_verts_t  verts = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    tna_pkg::tna_result_t res;
    int                   failures;
    int                   pending;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    bit                   hold_request = 1'b0;
    int                   quiet_cycles = 0;

    triangle_normal_and_area u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .vert_valid(vert_valid),
        .vert_ready(vert_ready),
        .verts     (verts),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    tna_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .vert_valid(vert_valid),
        .vert_ready(vert_ready),
        .verts     (verts),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .failures  (failures),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            res_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_request = 1'b0;
        end
        res_ready = (int'($urandom_range(99)) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((vert_valid && vert_ready) || (res_valid && res_ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [15:0] rand_coord(int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(64) - 32);
            2: return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(2048) - 1024);
        endcase
    endfunction

    function automatic tna_pkg::tna_verts_t rand_triangle();
        tna_pkg::tna_verts_t t;
        int                  kind;
        int                  mode;
        logic [15:0]         dx, dy, dz;
        mode = $urandom_range(9);
        kind = (mode < 4) ? 0 : (mode < 6) ? 3 : (mode < 8) ? 1 : 2;
        t.v0_x = rand_coord(kind);
        t.v0_y = rand_coord(kind);
        t.v0_z = rand_coord(kind);
        t.v1_x = rand_coord(kind);
        t.v1_y = rand_coord(kind);
        t.v1_z = rand_coord(kind);
        t.v2_x = rand_coord(kind);
        t.v2_y = rand_coord(kind);
        t.v2_z = rand_coord(kind);
        if ($urandom_range(9) == 0)
        begin
            dx = rand_coord(1);
            dy = rand_coord(1);
            dz = rand_coord(1);
            t.v0_x = rand_coord(3);
            t.v0_y = rand_coord(3);
            t.v0_z = rand_coord(3);
            t.v1_x = t.v0_x + dx;
            t.v1_y = t.v0_y + dy;
            t.v1_z = t.v0_z + dz;
            t.v2_x = t.v0_x + 16'(int'($urandom_range(6)) - 3) * dx;
            t.v2_y = t.v0_y + 16'(int'($urandom_range(6)) - 3) * dy;
            t.v2_z = t.v0_z + 16'(int'($urandom_range(6)) - 3) * dz;
        end
        return t;
    endfunction

    task automatic send_triangle(tna_pkg::tna_verts_t t);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            vert_valid = 1'b0;
            @(negedge clk);
        end
        vert_valid = 1'b1;
        verts = t;
        do @(posedge clk); while (!vert_ready);
        @(negedge clk);
    endtask

    task automatic send_xyz(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                            logic [15:0] b0, logic [15:0] b1, logic [15:0] b2,
                            logic [15:0] c0, logic [15:0] c1, logic [15:0] c2);
        tna_pkg::tna_verts_t t;
        t = {a0, a1, a2, b0, b1, b2, c0, c1, c2};
        send_triangle(t);
    endtask

    task automatic wait_drained();
        vert_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_xyz(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_xyz(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_xyz(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 16'h8000);
        send_xyz(0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_xyz(0, 0, 0, 0, 256, 0, 256, 0, 0);
        send_xyz(0, 0, 0, 0, 256, 0, 0, 0, 256);
        send_xyz(0, 0, 0, 0, 0, 256, 0, 256, 0);
        send_xyz(0, 0, 0, 0, 0, 256, 256, 0, 0);
        send_xyz(0, 0, 0, 256, 0, 0, 0, 0, 256);
        send_xyz(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_xyz(0, 0, 0, 1, 1, 1, 2, 2, 2);
        send_xyz(10, 20, 30, 15, 25, 35, 25, 35, 45);
        send_xyz(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                 16'h8000, 16'h7FFF, 16'h8000);
        send_xyz(16'h8000, 16'h8000, 0, 16'h7FFF, 16'h8000, 16'h7FFF,
                 16'h8000, 16'h7FFF, 16'h8000);
        send_xyz(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                 16'h7FFF, 16'h7FFF, 16'h8000);
        send_xyz(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                 16'h8000, 16'h8000, 16'h7FFF);
        send_xyz(5, 5, 5, 5, 5, 5, 100, 7, 9);
        send_xyz(1, 2, 3, 1, 2, 4, 1, 3, 3);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 10 : 0;
            recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 10 : 0;
            if (phase == 0)
            begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < 420; n++)
            begin
                send_triangle(rand_triangle());
                if (n == 200)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (100) @(negedge clk);
        if (failures == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== triangle_normal_and_area.f =====
+incdir+rtl/core
rtl/core/tna_pkg.sv
rtl/core/tna_front.sv
rtl/core/tna_queue.sv
rtl/core/tna_back.sv
rtl/core/triangle_normal_and_area.sv
rtl/core/tna_checker.sv
test/tna_checker.sv
test/testbench.sv
